### design/external_interrupt_controller_assert.svh
// assertion macros shared by the checker of the external interrupt controller
// depends on a clk and rst signal in the scope where a macro is used
`ifndef EXTERNAL_INTERRUPT_CONTROLLER_ASSERT_SVH
`define EXTERNAL_INTERRUPT_CONTROLLER_ASSERT_SVH

// condition must hold at every edge outside reset
`define EIC_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("eic assertion failed");

// consequent must hold in the cycle after the antecedent
`define EIC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("eic assertion failed");

`endif

### design/eic_pkg.sv
// shared constants, register codes and types of the external interrupt controller
// no dependencies
`default_nettype none

package eic_pkg;

  localparam int LINE_COUNT  = 16;
  localparam int PORT_COUNT  = 8;
  localparam int INPUT_PORTS = 8;
  localparam int PORT_LIMIT  = (PORT_COUNT < INPUT_PORTS) ? PORT_COUNT : INPUT_PORTS;
  localparam int SEL_W       = $clog2(INPUT_PORTS);

  localparam int LINES       = 16;
  localparam int PINS_W      = 16;
  localparam int SELECT_W    = 4;
  localparam int IRQ_W       = 7;
  localparam int LINE_IDX_W  = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  // irq grouping: lines 0 to 4 alone, 5 to 9 shared, 10 to 15 shared
  localparam int SINGLE_LAST = 4;
  localparam int GROUP_A_LO  = 5;
  localparam int GROUP_A_HI  = 9;
  localparam int GROUP_B_LO  = 10;
  localparam int GROUP_B_HI  = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTERRUPT_MASK = 2'd0,
    REG_RISING_ENABLE  = 2'd1,
    REG_FALLING_ENABLE = 2'd2,
    REG_PORT_SELECT    = 2'd3
  } reg_index_t;

  typedef logic [INPUT_PORTS-1:0] port_levels_t;

  typedef struct packed {
    logic                mask;
    logic                rise_en;
    logic                fall_en;
    logic [SELECT_W-1:0] sel;
  } lane_cfg_t;

  typedef struct packed {
    logic tick;
    logic clear;
  } lane_ctrl_t;

  typedef struct packed {
    logic [LINES-1:0]      pending_flags;
    logic [IRQ_W-1:0]      irq_requests;
    logic [LINE_IDX_W-1:0] service_line;
    logic                  service_valid;
  } result_t;

endpackage

`default_nettype wire

### design/eic_if.sv
// handshake interfaces of the external interrupt controller: request, result, config
// depends on eic_pkg
`default_nettype none

interface eic_in_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [eic_pkg::LINES-1:0] clear_mask;
  logic [eic_pkg::PINS_W-1:0] port_a_pins;
  logic [eic_pkg::PINS_W-1:0] port_b_pins;
  logic [eic_pkg::PINS_W-1:0] port_c_pins;
  logic [eic_pkg::PINS_W-1:0] port_d_pins;
  logic [eic_pkg::PINS_W-1:0] port_e_pins;
  logic [eic_pkg::PINS_W-1:0] port_f_pins;
  logic [eic_pkg::PINS_W-1:0] port_g_pins;
  logic [eic_pkg::PINS_W-1:0] port_h_pins;

  modport source (output valid, action, clear_mask, port_a_pins, port_b_pins,
                  port_c_pins, port_d_pins, port_e_pins, port_f_pins,
                  port_g_pins, port_h_pins, input ready);
  modport sink (input valid, action, clear_mask, port_a_pins, port_b_pins,
                port_c_pins, port_d_pins, port_e_pins, port_f_pins,
                port_g_pins, port_h_pins, output ready);
endinterface

interface eic_out_if;
  logic                          valid;
  logic                          ready;
  logic [eic_pkg::LINES-1:0]     pending_flags;
  logic [eic_pkg::IRQ_W-1:0]     irq_requests;
  logic [eic_pkg::LINE_IDX_W-1:0] service_line;
  logic                          service_valid;

  modport source (output valid, pending_flags, irq_requests, service_line,
                  service_valid, input ready);
  modport sink (input valid, pending_flags, irq_requests, service_line,
                service_valid, output ready);
endinterface

interface eic_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [eic_pkg::CFG_IDX_W-1:0]  index;
  logic [eic_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/eic_lane.sv
// one interrupt line: port routing, edge detection and the pending latch
// depends on eic_pkg
`default_nettype none

module eic_lane (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire eic_pkg::lane_ctrl_t   ctrl,
  input  wire eic_pkg::lane_cfg_t    cfg,
  input  wire eic_pkg::port_levels_t levels,
  input  wire logic                  clear_bit,
  output logic                       pending_next
);

  logic prev_level;
  logic pending;
  logic level;
  logic edge_hit;

  // selectors past the populated ports read low
  always_comb begin
    if (int'(cfg.sel) < eic_pkg::PORT_LIMIT) begin
      level = levels[cfg.sel[eic_pkg::SEL_W-1:0]];
    end else begin
      level = 1'b0;
    end
  end

  assign edge_hit = (level & ~prev_level & cfg.rise_en) | (~level & prev_level & cfg.fall_en);

  always_comb begin
    if (ctrl.tick) begin
      pending_next = pending | (edge_hit & cfg.mask);
    end else if (ctrl.clear) begin
      pending_next = pending & ~clear_bit;
    end else begin
      pending_next = pending;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level <= 1'b0;
      pending    <= 1'b0;
    end else begin
      pending <= pending_next;
      if (ctrl.tick) begin
        prev_level <= level;
      end
    end
  end

endmodule

`default_nettype wire

### design/eic_merge.sv
// merge of the lane pending bits: irq grouping, lowest line search, result queue
// depends on eic_pkg
`default_nettype none

module eic_merge (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [eic_pkg::LINES-1:0]  pending_next,
  output logic                            space,
  output logic                            res_valid,
  input  wire logic                       res_ready,
  output eic_pkg::result_t                res
);

  eic_pkg::result_t merged;
  eic_pkg::result_t queue [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  always_comb begin
    merged = '0;
    merged.pending_flags = pending_next;
    merged.irq_requests[eic_pkg::SINGLE_LAST:0] = pending_next[eic_pkg::SINGLE_LAST:0];
    merged.irq_requests[eic_pkg::SINGLE_LAST+1] =
      |pending_next[eic_pkg::GROUP_A_HI:eic_pkg::GROUP_A_LO];
    merged.irq_requests[eic_pkg::SINGLE_LAST+2] =
      |pending_next[eic_pkg::GROUP_B_HI:eic_pkg::GROUP_B_LO];
    merged.service_valid = |pending_next;
    // scan from the top so the lowest set line wins
    for (int n = eic_pkg::LINES - 1; n >= 0; n--) begin
      if (pending_next[n]) begin
        merged.service_line = eic_pkg::LINE_IDX_W'(n);
      end
    end
  end

  assign pop       = res_valid & res_ready;
  assign space     = (count != 2'd2);
  assign res_valid = (count != 2'd0);
  assign res       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= merged;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

### design/external_interrupt_controller.sv
// top level of the external interrupt controller: config registers, lines, merge
// depends on eic_pkg, eic_if, eic_lane, eic_merge
//
// usage
//   request carries one item: action 0 samples the eight pin ports, action 1
//   clears pending bits selected by clear_mask (write one to clear).
//   result returns one item per request: pending bits after that request,
//   the seven irq requests, the lowest pending line and an any-pending flag.
//   cfg writes interrupt_mask, rising_enable, falling_enable (index 0 to 2)
//   and the 64-bit port_select (index 3); it is always ready and should be
//   written only while no request is in flight.
// timing
//   one request per cycle sustained while the result queue has space; each
//   line has its own lane, so the sixteen lines update in the same cycle and
//   the merge stage combines them; a result is written to the queue on accept.
// reset and stall
//   rst clears pending bits, previous levels, config registers and queue pointers.
//   results sit in a two-entry queue; request ready drops only when both
//   entries hold results that the receiver has not taken.
`default_nettype none

module external_interrupt_controller (
  input  wire logic clk,
  input  wire logic rst,
  eic_in_if.sink    request,
  eic_out_if.source result,
  eic_cfg_if.sink   cfg
);

  logic [eic_pkg::LINES-1:0]      interrupt_mask;
  logic [eic_pkg::LINES-1:0]      rising_enable;
  logic [eic_pkg::LINES-1:0]      falling_enable;
  logic [eic_pkg::CFG_DATA_W-1:0] port_select;

  logic                           accept;
  logic                           space;
  eic_pkg::lane_ctrl_t            ctrl;
  logic [eic_pkg::LINES-1:0]      pending_next;
  logic [eic_pkg::PINS_W-1:0]     pins [eic_pkg::INPUT_PORTS];
  eic_pkg::result_t               res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      interrupt_mask <= '0;
      rising_enable  <= '0;
      falling_enable <= '0;
      port_select    <= '0;
    end else if (cfg.valid) begin
      case (eic_pkg::reg_index_t'(cfg.index))
        eic_pkg::REG_INTERRUPT_MASK: interrupt_mask <= cfg.data[eic_pkg::LINES-1:0];
        eic_pkg::REG_RISING_ENABLE:  rising_enable  <= cfg.data[eic_pkg::LINES-1:0];
        eic_pkg::REG_FALLING_ENABLE: falling_enable <= cfg.data[eic_pkg::LINES-1:0];
        eic_pkg::REG_PORT_SELECT:    port_select    <= cfg.data;
        default: ;
      endcase
    end
  end

  assign request.ready = space;
  assign accept        = request.valid & space;
  assign ctrl.tick     = accept & ~request.action;
  assign ctrl.clear    = accept & request.action;

  assign pins[0] = request.port_a_pins;
  assign pins[1] = request.port_b_pins;
  assign pins[2] = request.port_c_pins;
  assign pins[3] = request.port_d_pins;
  assign pins[4] = request.port_e_pins;
  assign pins[5] = request.port_f_pins;
  assign pins[6] = request.port_g_pins;
  assign pins[7] = request.port_h_pins;

  for (genvar n = 0; n < eic_pkg::LINES; n++) begin : g_line
    if (n < eic_pkg::LINE_COUNT) begin : g_lane
      eic_pkg::lane_cfg_t    lane_cfg;
      eic_pkg::port_levels_t levels;

      assign lane_cfg.mask    = interrupt_mask[n];
      assign lane_cfg.rise_en = rising_enable[n];
      assign lane_cfg.fall_en = falling_enable[n];
      assign lane_cfg.sel     = port_select[eic_pkg::SELECT_W*n +: eic_pkg::SELECT_W];

      for (genvar p = 0; p < eic_pkg::INPUT_PORTS; p++) begin : g_port
        assign levels[p] = pins[p][n];
      end

      eic_lane u_lane (
        .clk          (clk),
        .rst          (rst),
        .ctrl         (ctrl),
        .cfg          (lane_cfg),
        .levels       (levels),
        .clear_bit    (request.clear_mask[n]),
        .pending_next (pending_next[n])
      );
    end else begin : g_unused
      assign pending_next[n] = 1'b0;
    end
  end

  eic_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .push         (accept),
    .pending_next (pending_next),
    .space        (space),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res          (res)
  );

  assign result.pending_flags = res.pending_flags;
  assign result.irq_requests  = res.irq_requests;
  assign result.service_line  = res.service_line;
  assign result.service_valid = res.service_valid;

endmodule

`default_nettype wire

### design/eic_checker.sv
// port-level checks of the external interrupt controller, bound to the top level
// depends on eic_pkg and external_interrupt_controller_assert.svh
`default_nettype none

`include "external_interrupt_controller_assert.svh"

module eic_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [eic_pkg::LINES-1:0]       pending_flags,
  input wire logic [eic_pkg::IRQ_W-1:0]       irq_requests,
  input wire logic [eic_pkg::LINE_IDX_W-1:0]  service_line,
  input wire logic                            service_valid
);

  `EIC_ASSERT(a_valid_matches_pending, !out_valid || (service_valid == (pending_flags != '0)))
  `EIC_ASSERT(a_line_is_pending, !(out_valid && service_valid) || pending_flags[service_line])
  `EIC_ASSERT(a_low_line_clear, !(out_valid && service_valid) || ((pending_flags & ((16'd1 << service_line) - 16'd1)) == '0))
  `EIC_ASSERT(a_shared_irq, !out_valid || ((irq_requests[5] == |pending_flags[9:5]) && (irq_requests[6] == |pending_flags[15:10])))
  `EIC_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(pending_flags) && $stable(service_line))

endmodule

bind external_interrupt_controller eic_checker u_eic_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .pending_flags (result.pending_flags),
  .irq_requests  (result.irq_requests),
  .service_line  (result.service_line),
  .service_valid (result.service_valid)
);

`default_nettype wire

### tb/tb_top.sv
// self-checking bench for the external interrupt controller: phased register settings,
// directed and random pin and clear requests, scoreboard against an in-bench predictor
// depends on eic_pkg, eic_if and the external_interrupt_controller rtl
`timescale 1ns / 100ps

module tb_top;
  import eic_pkg::*;

  localparam logic ACT_SAMPLE      = 1'b0;
  localparam logic ACT_CLEAR       = 1'b1;
  localparam int   STALL_LIMIT     = 2000;
  localparam int   HOLD_OFF_CYCLES = 150;
  localparam int   SETTLE_CYCLES   = 4;
  localparam int   RANDOM_PHASES   = 6;
  localparam int   PHASE_ITEMS     = 125;
  localparam int   REPORT_LIMIT    = 10;

  typedef struct packed {
    logic                  action;
    logic [LINES-1:0]      clear_mask;
    logic [7:0][PINS_W-1:0] pins;
  } pin_request_t;

  logic clk;
  logic rst;

  eic_in_if  request_bus();
  eic_out_if result_bus();
  eic_cfg_if cfg_bus();

  external_interrupt_controller u_top (
    .clk    (clk),
    .rst    (rst),
    .request(request_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  // predictor state
  logic [LINES-1:0] model_pending;
  logic [LINES-1:0] model_levels;
  logic [LINES-1:0] model_mask;
  logic [LINES-1:0] model_rise;
  logic [LINES-1:0] model_fall;
  logic [63:0]      model_select;

  pin_request_t pin_requests[$];
  result_t      expected_status[$];
  pin_request_t next_req;
  pin_request_t seen_req;
  result_t      want;

  logic [7:0][PINS_W-1:0] last_pins;
  logic [LINES-1:0]       lines_raised;

  bit sender_gaps_on;
  bit receiver_stalls_on;
  bit hold_off_req;
  int send_gap;
  int stall_left;
  int handshake_count;
  int mismatch_count;
  int samples_sent;
  int clears_sent;
  int results_checked;
  int writes_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] random_word();
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic result_t predict_pending(pin_request_t r);
    logic [LINES-1:0]    levels;
    logic [SELECT_W-1:0] sel;
    result_t             res;
    if (r.action == ACT_SAMPLE) begin
      levels = '0;
      for (int n = 0; n < LINES; n++) begin
        sel = model_select[SELECT_W*n +: SELECT_W];
        // selectors past the last port and lines past the line count read low
        if (n < LINE_COUNT && sel < PORT_LIMIT) levels[n] = r.pins[sel][n];
      end
      model_pending = model_pending |
        (((levels & ~model_levels & model_rise) | (~levels & model_levels & model_fall))
         & model_mask);
      model_levels = levels;
    end else begin
      model_pending = model_pending & ~r.clear_mask;
    end
    res.pending_flags = model_pending;
    res.irq_requests  = {|model_pending[GROUP_B_HI:GROUP_B_LO],
                         |model_pending[GROUP_A_HI:GROUP_A_LO],
                         model_pending[SINGLE_LAST:0]};
    res.service_valid = |model_pending;
    res.service_line  = '0;
    for (int n = LINES - 1; n >= 0; n--)
      if (model_pending[n]) res.service_line = n[LINE_IDX_W-1:0];
    return res;
  endfunction

  function automatic void note_mismatch(string what, logic [15:0] exp_val, logic [15:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("mismatch on %s: expected %h, got %h", what, exp_val, got);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      request_bus.valid <= 1'b0;
      send_gap = 0;
    end else if (!request_bus.valid || request_bus.ready) begin
      if (send_gap > 0 || pin_requests.size() == 0) begin
        if (send_gap > 0) send_gap--;
        request_bus.valid <= 1'b0;
      end else begin
        next_req = pin_requests.pop_front();
        request_bus.valid       <= 1'b1;
        request_bus.action      <= next_req.action;
        request_bus.clear_mask  <= next_req.clear_mask;
        request_bus.port_a_pins <= next_req.pins[0];
        request_bus.port_b_pins <= next_req.pins[1];
        request_bus.port_c_pins <= next_req.pins[2];
        request_bus.port_d_pins <= next_req.pins[3];
        request_bus.port_e_pins <= next_req.pins[4];
        request_bus.port_f_pins <= next_req.pins[5];
        request_bus.port_g_pins <= next_req.pins[6];
        request_bus.port_h_pins <= next_req.pins[7];
        send_gap = sender_gaps_on ? draw_gap() : 0;
      end
    end
  end

  // result receiver, with random stalls and one long hold-off on demand
  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
      stall_left = 0;
    end else if (hold_off_req) begin
      hold_off_req = 1'b0;
      stall_left = HOLD_OFF_CYCLES - 1;
      result_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= 1'b1;
      if (receiver_stalls_on) stall_left = draw_gap();
    end
  end

  // monitor: register writes, result checks, predictions for accepted requests
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          REG_INTERRUPT_MASK: model_mask   = cfg_bus.data[LINES-1:0];
          REG_RISING_ENABLE:  model_rise   = cfg_bus.data[LINES-1:0];
          REG_FALLING_ENABLE: model_fall   = cfg_bus.data[LINES-1:0];
          REG_PORT_SELECT:    model_select = cfg_bus.data;
          default: ;
        endcase
        writes_done++;
        handshake_count++;
      end
      if (result_bus.valid && result_bus.ready) begin
        handshake_count++;
        if (expected_status.size() == 0) begin
          note_mismatch("result with nothing outstanding", '0, result_bus.pending_flags);
        end else begin
          want = expected_status.pop_front();
          results_checked++;
          if (result_bus.pending_flags !== want.pending_flags)
            note_mismatch("pending_flags", want.pending_flags, result_bus.pending_flags);
          if (result_bus.irq_requests !== want.irq_requests)
            note_mismatch("irq_requests", 16'(want.irq_requests),
                          16'(result_bus.irq_requests));
          if (result_bus.service_line !== want.service_line)
            note_mismatch("service_line", 16'(want.service_line),
                          16'(result_bus.service_line));
          if (result_bus.service_valid !== want.service_valid)
            note_mismatch("service_valid", 16'(want.service_valid),
                          16'(result_bus.service_valid));
          lines_raised = lines_raised | want.pending_flags;
        end
      end
      if (request_bus.valid && request_bus.ready) begin
        handshake_count++;
        seen_req.action     = request_bus.action;
        seen_req.clear_mask = request_bus.clear_mask;
        seen_req.pins       = {request_bus.port_h_pins, request_bus.port_g_pins,
                               request_bus.port_f_pins, request_bus.port_e_pins,
                               request_bus.port_d_pins, request_bus.port_c_pins,
                               request_bus.port_b_pins, request_bus.port_a_pins};
        if (seen_req.action == ACT_SAMPLE) samples_sent++;
        else clears_sent++;
        expected_status.push_back(predict_pending(seen_req));
      end
    end
  end

  // watchdog on cycles with no handshake on any channel
  initial begin : watchdog
    int last_count;
    int quiet;
    last_count = 0;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(negedge clk);
      if (handshake_count != last_count) begin
        last_count = handshake_count;
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("external_interrupt_controller verification failed");
    $finish;
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (pin_requests.size() != 0 || request_bus.valid || expected_status.size() != 0);
  endtask

  task automatic write_register(reg_index_t idx, logic [63:0] value);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic apply_setting(logic [15:0] mask, logic [15:0] rise, logic [15:0] fall,
                               logic [63:0] sel);
    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_register(REG_INTERRUPT_MASK, 64'(mask));
    write_register(REG_RISING_ENABLE, 64'(rise));
    write_register(REG_FALLING_ENABLE, 64'(fall));
    write_register(REG_PORT_SELECT, sel);
    @(negedge clk);
  endtask

  task automatic write_random_setting();
    logic [63:0] sel_word;
    logic [15:0] mask;
    logic [15:0] rise;
    logic [15:0] fall;
    sel_word = '0;
    for (int n = 0; n < LINES; n++)
      sel_word[SELECT_W*n +: SELECT_W] = ($urandom_range(0, 99) < 85) ?
        4'($urandom_range(0, 7)) : 4'($urandom_range(8, 15));
    mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (random_word() | random_word());
    rise = ($urandom_range(0, 3) == 0) ? 16'hFFFF : random_word();
    fall = ($urandom_range(0, 3) == 0) ? 16'hFFFF : random_word();
    apply_setting(mask, rise, fall, sel_word);
  endtask

  task automatic queue_sample(logic [7:0][PINS_W-1:0] pins);
    pin_request_t r;
    r.action     = ACT_SAMPLE;
    r.clear_mask = random_word();
    r.pins       = pins;
    pin_requests.push_back(r);
  endtask

  task automatic queue_clear(logic [15:0] mask);
    pin_request_t r;
    r.action     = ACT_CLEAR;
    r.clear_mask = mask;
    for (int p = 0; p < 8; p++) r.pins[p] = random_word();
    pin_requests.push_back(r);
  endtask

  task automatic queue_random_item();
    int port;
    if ($urandom_range(0, 99) < 20) begin
      case ($urandom_range(0, 5))
        0: queue_clear(16'hFFFF);
        1: queue_clear(16'h0001 << $urandom_range(0, 15));
        2: queue_clear(16'h0000);
        default: queue_clear(random_word());
      endcase
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2: for (int p = 0; p < 8; p++) last_pins[p] = random_word();
        3: begin
          port = $urandom_range(0, 7);
          last_pins[port] = ~last_pins[port];
        end
        // sparse toggles keep edges isolated
        default: for (int p = 0; p < 8; p++)
          last_pins[p] = last_pins[p] ^ (random_word() & random_word() & random_word());
      endcase
      queue_sample(last_pins);
    end
  endtask

  initial begin
    logic [7:0][PINS_W-1:0] dp;
    request_bus.valid       = 1'b0;
    request_bus.action      = ACT_SAMPLE;
    request_bus.clear_mask  = '0;
    request_bus.port_a_pins = '0;
    request_bus.port_b_pins = '0;
    request_bus.port_c_pins = '0;
    request_bus.port_d_pins = '0;
    request_bus.port_e_pins = '0;
    request_bus.port_f_pins = '0;
    request_bus.port_g_pins = '0;
    request_bus.port_h_pins = '0;
    result_bus.ready        = 1'b0;
    cfg_bus.valid           = 1'b0;
    cfg_bus.index           = REG_INTERRUPT_MASK;
    cfg_bus.data            = '0;
    model_pending = '0;
    model_levels  = '0;
    model_mask    = '0;
    model_rise    = '0;
    model_fall    = '0;
    model_select  = '0;
    last_pins     = '0;
    lines_raised  = '0;
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b1;
    hold_off_req       = 1'b0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset setting: every trigger disabled, toggles do nothing
    queue_sample({8{16'hFFFF}});
    queue_sample('0);

    // rising edges on port a, irq grouping and lowest-line scan
    apply_setting(16'hFFFF, 16'hFFFF, 16'h0000, 64'h0);
    dp = '0;
    dp[0] = 16'h0001; queue_sample(dp);
    dp[0] = 16'h8001; queue_sample(dp);
    queue_clear(16'h0001);
    queue_clear(16'h0001);  // clearing a line that is not pending
    dp[0] = 16'h8221; queue_sample(dp);
    dp[0] = 16'h8621; queue_sample(dp);
    dp = {8{16'hFFFF}}; dp[0] = 16'h0000; queue_sample(dp);
    queue_clear(16'hFFFF);
    queue_clear(16'h0000);
    dp = '0; dp[0] = 16'h0010; queue_sample(dp);
    queue_clear(16'hFFFF);

    // falling edges, one line per port, upper lines on unused selectors
    apply_setting(16'hFFFF, 16'h0000, 16'hFFFF, 64'hFEDC_BA98_7654_3210);
    queue_sample({8{16'hFFFF}});
    queue_sample('0);
    dp = '0; dp[7] = 16'hFFFF; queue_sample(dp);
    queue_clear(16'h00F0);
    queue_sample({8{16'hFFFF}});
    queue_sample('0);

    // all lines masked: pending lines stay, new edges are dropped
    apply_setting(16'h0000, 16'hFFFF, 16'hFFFF, 64'hFEDC_BA98_7654_3210);
    queue_sample({8{16'hFFFF}});
    queue_sample('0);
    queue_clear(16'h0F0F);
    queue_clear(16'hFFFF);

    // every selector unused: no line ever sees a high level
    apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_sample({8{16'hFFFF}});
    queue_sample('0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_random_setting();
      sender_gaps_on     = (ph != 0) && (ph != 2);
      receiver_stalls_on = (ph != 0);
      // long receiver hold-off while the sender keeps pushing
      if (ph == 2) hold_off_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 4 && i == PHASE_ITEMS / 2) wait_idle();
        queue_random_item();
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_status.size() != 0) begin
      mismatch_count += expected_status.size();
      $display("%0d results never arrived", expected_status.size());
    end
    $display("run: %0d samples, %0d clears, %0d register writes, %0d results checked",
             samples_sent, clears_sent, writes_done, results_checked);
    $display("lines seen pending %b, mismatches %0d", lines_raised, mismatch_count);
    if (mismatch_count == 0) begin
      $display("external_interrupt_controller verification clean");
    end else begin
      $display("external_interrupt_controller verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/eic_pkg.sv
design/eic_if.sv
design/eic_lane.sv
design/eic_merge.sv
design/external_interrupt_controller.sv
design/eic_checker.sv
tb/tb_top.sv
